>>> hdl/rrks_pkg.sv
// rrks_pkg: shared types and constants for the random replacement key set.
// No dependencies.
`default_nettype none
package rrks_pkg;
	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [1:0] CMD_TOUCH  = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_SPARE  = 2'd3;

	localparam logic [2:0] ST_PRESENT  = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_EVICTED  = 3'd2;
	localparam logic [2:0] ST_REMOVED  = 3'd3;
	localparam logic [2:0] ST_MISSED   = 3'd4;
	localparam logic [2:0] ST_FOUND    = 3'd5;
	localparam logic [2:0] ST_ABSENT   = 3'd6;

	localparam logic [1:0] REG_SIZE_LIMIT = 2'd0;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] key;
		logic [15:0] random_pick;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        evicted_valid;
		logic [31:0] evicted_key;
		logic [6:0]  entry_count;
	} out_item_t;

	// queue entry between front and back
	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] key;
		logic [15:0] random_pick;
	} job_t;
endpackage
`default_nettype wire

>>> hdl/rrks_front.sv
// rrks_front: two-entry input queue towards the back end.
// Depends on rrks_pkg.
`default_nettype none
module rrks_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rrks_pkg::in_item_t in_data,
	output logic                   job_valid,
	input  wire logic              job_take,
	output rrks_pkg::job_t         job
);
	rrks_pkg::job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q].command     <= in_data.command;
			mem_q[wp_q].key         <= in_data.key;
			mem_q[wp_q].random_pick <= in_data.random_pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (job_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_take);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overrun");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("queue underrun");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("bad count");
endmodule
`default_nettype wire

>>> hdl/rrks_back.sv
// rrks_back: key store, parallel match and update; registered result.
// Depends on rrks_pkg.
`default_nettype none
module rrks_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	output logic                   job_take,
	input  wire rrks_pkg::job_t    job,
	input  wire logic [6:0]        size_limit,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rrks_pkg::out_item_t    out_data
);
	localparam int IW = rrks_pkg::IDX_W;
	localparam int CW = rrks_pkg::CNT_W;

	logic [rrks_pkg::KEY_BITS-1:0] slots_q [rrks_pkg::CAPACITY];
	logic [CW-1:0]  count_q;
	logic [rrks_pkg::CAPACITY-1:0] hit;
	logic           found;
	logic [IW-1:0]  pos;
	logic [CW-1:0]  limit;
	logic [CW+15:0] prod;
	logic [IW-1:0]  victim;
	logic [IW-1:0]  last;
	logic [rrks_pkg::KEY_BITS-1:0] k;
	rrks_pkg::out_item_t res;
	logic           wr_en;
	logic [IW-1:0]  wr_idx;
	logic [rrks_pkg::KEY_BITS-1:0] wr_val;
	logic [CW-1:0]  count_d;

	assign job_take = job_valid && !(out_valid && out_stall);
	assign k = job.key[rrks_pkg::KEY_BITS-1:0];

	always_comb begin
		for (int i = 0; i < rrks_pkg::CAPACITY; i++)
			hit[i] = (slots_q[i] == k) && (CW'(i) < count_q);
	end

	always_comb begin
		found = 1'b0;
		pos = '0;
		for (int i = 0; i < rrks_pkg::CAPACITY; i++)
			if (hit[i] && !found) begin
				found = 1'b1;
				pos = IW'(i);
			end
	end

	always_comb begin
		if (size_limit == 7'd0) limit = CW'(1);
		else if (32'(size_limit) > rrks_pkg::CAPACITY) limit = CW'(rrks_pkg::CAPACITY);
		else limit = CW'(size_limit);
		prod   = (CW+16)'(job.random_pick) * (CW+16)'(count_q);
		victim = prod[IW+15:16];
		last   = IW'(count_q - CW'(1));
	end

	always_comb begin
		res = '0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_val = k;
		count_d = count_q;
		unique case (job.command)
			rrks_pkg::CMD_TOUCH: begin
				if (found) res.status = rrks_pkg::ST_PRESENT;
				else if (count_q < limit) begin
					wr_en = 1'b1;
					wr_idx = IW'(count_q);
					count_d = count_q + CW'(1);
					res.status = rrks_pkg::ST_INSERTED;
				end else begin
					wr_en = 1'b1;
					wr_idx = victim;
					res.status = rrks_pkg::ST_EVICTED;
					res.evicted_valid = 1'b1;
					res.evicted_key = 32'(slots_q[victim]);
				end
			end
			rrks_pkg::CMD_REMOVE: begin
				if (found) begin
					wr_en = 1'b1;
					wr_idx = pos;
					wr_val = slots_q[last];
					count_d = count_q - CW'(1);
					res.status = rrks_pkg::ST_REMOVED;
				end else res.status = rrks_pkg::ST_MISSED;
			end
			default: res.status = found ? rrks_pkg::ST_FOUND : rrks_pkg::ST_ABSENT;
		endcase
		res.entry_count = 7'(count_d);
	end

	always_ff @(posedge clk) begin
		if (job_take && wr_en) slots_q[wr_idx] <= wr_val;
		if (job_take) out_data <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (job_take) begin
				count_q <= count_d;
				out_valid <= 1'b1;
			end else if (!out_stall) out_valid <= 1'b0;
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= rrks_pkg::CAPACITY) else $error("count overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result lost");
	a_hit1: assert property (@(posedge clk) disable iff (!arst_n)
		job_take && job.command == rrks_pkg::CMD_REMOVE && found
		|=> count_q == $past(count_q) - CW'(1))
		else $error("remove count");
endmodule
`default_nettype wire

>>> hdl/random_replacement_key_set.sv
// random_replacement_key_set: top level, APB register and front/back wiring.
// Depends on rrks_pkg, rrks_front, rrks_back.
//
// channel | direction | payload         | handshake
// in      | input     | in_item_t       | in_valid / in_stall
// out     | output    | out_item_t      | out_valid / out_stall
// apb     | input     | size_limit (0x0)| psel/penable/pwrite, pready=1
//
// One item per cycle sustained while out_stall is low; an accepted transfer passes
// the queue register, then the result register. The back end sets the rate:
// its 64-way parallel key match and slot update.
// Reset clears the count (store contents stay unknown, never read) and sets
// the size limit to 64. A stalled result holds; the front queue keeps two items.
`default_nettype none
module random_replacement_key_set (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire rrks_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output rrks_pkg::out_item_t     out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [1:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	logic [6:0] size_limit_q;
	logic job_valid, job_take;
	rrks_pkg::job_t job;

	assign pready = 1'b1;
	// single register at address zero
	assign prdata = (paddr == rrks_pkg::REG_SIZE_LIMIT) ? {25'd0, size_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_limit_q <= 7'd64;
		else if (psel && penable && pwrite && paddr == rrks_pkg::REG_SIZE_LIMIT)
			size_limit_q <= pwdata[6:0];
	end

	rrks_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.job_valid, .job_take, .job
	);

	rrks_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .job,
		.size_limit(size_limit_q), .out_valid, .out_stall, .out_data
	);
endmodule
`default_nettype wire
